@@ src/oacs_pkg.sv @@
package oacs_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int RANGE_W     = 13;
    localparam int CMD_W       = 3;
    localparam int PCT_W       = 7;
    localparam int FTIME_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Range conversion: distance = RANGE_DIVIDEND / (raw - RAW_KNEE), raw at or
    // below the knee counts as RAW_SUBST.
    localparam logic [RANGE_W-1:0]     RANGE_DIVIDEND = 13'd4800;
    localparam logic [SAMPLE_BITS-1:0] RAW_KNEE       = 10'd20;
    localparam logic [SAMPLE_BITS-1:0] RAW_SUBST      = 10'd30;

    localparam logic [SAMPLE_BITS-1:0] TOLERANCE_RST   = 10'd50;
    localparam logic [SAMPLE_BITS-1:0] NOISE_FLOOR_RST = 10'd5;
    localparam logic [RANGE_W-1:0]     NEAR_LIMIT_RST  = 13'd40;

    localparam logic [PCT_W-1:0]   PCT_CENTER  = 7'd100;
    localparam logic [FTIME_W-1:0] FTIME_BASE  = 10'd100;

    // Reciprocal constants: x/10 = (x*205)>>11 for x < 1029,
    // x/5 = (x*3277)>>14 for x < 4096.
    localparam logic [7:0]  RECIP_10       = 8'd205;
    localparam int          RECIP_10_SHIFT = 11;
    localparam logic [11:0] RECIP_5        = 12'd3277;
    localparam int          RECIP_5_SHIFT  = 14;

    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ABOUT      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RIGHT      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VEER_LEFT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_VEER_RIGHT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 2'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] back_level;
        logic [SAMPLE_BITS-1:0] right_level;
        logic [SAMPLE_BITS-1:0] left_level;
        logic [SAMPLE_BITS-1:0] front_right_level;
        logic [SAMPLE_BITS-1:0] front_left_level;
        logic [SAMPLE_BITS-1:0] range_level;
    } scan_t;

    typedef struct packed {
        logic [CMD_W-1:0]   raw_command;
        logic [CMD_W-1:0]   issued_command;
        logic [PCT_W-1:0]   move_percent;
        logic [FTIME_W-1:0] forward_time_ms;
        logic [RANGE_W-1:0] range_cm;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0] issued;
        logic [PCT_W-1:0] oldest_pct;
    } hist_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE,
        ST_SQUARE,
        ST_SCALE
    } state_t;

    function automatic logic dominates(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] tol
    );
        logic [SAMPLE_BITS:0] bound;
        bound = {1'b0, b} + {1'b0, tol};
        return {1'b0, a} > bound;
    endfunction

endpackage

@@ src/obstacle_avoid_command_select.sv @@
// A scan runs through the bit-serial range divider, one quotient bit per cycle,
// then the decide, square and scale steps; no new scan is taken until the
// result has been loaded into the output register and the sequencer is back
// in idle.
// A new scan is taken while the previous result still waits in the output
// register. Reset (rst_n, async, active low) empties the pipeline, clears
// the command history and loads the default configuration values.
module obstacle_avoid_command_select #(
    parameter int HISTORY_DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  scan_valid,
    output logic                                  scan_ready,
    input  oacs_pkg::scan_t                       scan,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output oacs_pkg::result_t                     result,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [oacs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [oacs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SB = oacs_pkg::SAMPLE_BITS;
    localparam int PW = oacs_pkg::PCT_W;
    localparam int CW = oacs_pkg::CMD_W;
    localparam int SQ_W  = 2 * PW;
    localparam int QTR_W = SQ_W - 2;
    localparam int P10_W = SB + 8;
    localparam int P5_W  = QTR_W + 12;

    // Configuration registers
    logic [SB-1:0]                tolerance_reg;
    logic [SB-1:0]                noise_floor_reg;
    logic [oacs_pkg::RANGE_W-1:0] near_limit_reg;

    // Sequencer
    oacs_pkg::state_t state_reg, state_next;

    // Per-scan working registers (samples already cut at the noise floor)
    logic [SB-1:0] back_reg, right_reg, left_reg, fr_reg, fl_reg;
    logic [CW-1:0] cmd_reg;
    logic [CW-1:0] issued_reg;
    logic [PW-1:0] oper_reg;
    logic [SQ_W-1:0] sq_reg;

    // Output register
    logic              result_valid_reg;
    oacs_pkg::result_t result_reg;

    // Control strobes
    logic scan_xfer;
    logic div_start;
    logic div_done;
    logic hist_push;
    logic load_result;

    logic [SB-1:0]                divisor;
    logic [oacs_pkg::RANGE_W-1:0] range_cm;

    logic [CW-1:0] cmd_sel;
    logic [PW-1:0] pct_sel;
    logic          all_zero;
    logic          clear_ahead;
    logic [P10_W-1:0] pct_prod;
    logic [PW-1:0]    dist_pct;

    oacs_pkg::hist_stat_t hist_stat;

    logic [PW-1:0]             dev;
    logic [P5_W-1:0]           scale_prod;
    logic [oacs_pkg::FTIME_W-1:0] ftime;

    assign scan_ready = (state_reg == oacs_pkg::ST_IDLE);
    assign scan_xfer  = scan_valid && scan_ready;
    assign cfg_ready  = 1'b1;

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg   <= oacs_pkg::TOLERANCE_RST;
            noise_floor_reg <= oacs_pkg::NOISE_FLOOR_RST;
            near_limit_reg  <= oacs_pkg::NEAR_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                oacs_pkg::CFG_TOLERANCE:   tolerance_reg   <= cfg_data[SB-1:0];
                oacs_pkg::CFG_NOISE_FLOOR: noise_floor_reg <= cfg_data[SB-1:0];
                oacs_pkg::CFG_NEAR_LIMIT:  near_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Divisor for the range conversion: raw at or below the knee counts as
    // the substitute value, so the divisor is never zero.
    always_comb
    begin
        if (scan.range_level <= oacs_pkg::RAW_KNEE)
        begin
            divisor = oacs_pkg::RAW_SUBST - oacs_pkg::RAW_KNEE;
        end
        else
        begin
            divisor = scan.range_level - oacs_pkg::RAW_KNEE;
        end
    end

    assign div_start = scan_xfer;

    oacs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (oacs_pkg::RANGE_DIVIDEND),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (range_cm)
    );

    // Hold the floor-cut samples while the divider runs.
    always_ff @(posedge clk)
    begin
        if (scan_xfer)
        begin
            back_reg  <= (scan.back_level        < noise_floor_reg) ? '0 : scan.back_level;
            right_reg <= (scan.right_level       < noise_floor_reg) ? '0 : scan.right_level;
            left_reg  <= (scan.left_level        < noise_floor_reg) ? '0 : scan.left_level;
            fr_reg    <= (scan.front_right_level < noise_floor_reg) ? '0 : scan.front_right_level;
            fl_reg    <= (scan.front_left_level  < noise_floor_reg) ? '0 : scan.front_left_level;
        end
    end

    // Command choice. Priority: nothing seen, back, left, right dominating
    // all others, then the front pair; a front tie leaves no command.
    always_comb
    begin
        all_zero    = (back_reg == '0) && (right_reg == '0) && (left_reg == '0)
                      && (fr_reg == '0) && (fl_reg == '0);
        clear_ahead = (range_cm != '0) && (range_cm > near_limit_reg);
        pct_prod    = (fl_reg > fr_reg ? {8'd0, fl_reg} : {8'd0, fr_reg})
                      * {{SB{1'b0}}, oacs_pkg::RECIP_10};
        dist_pct    = pct_prod[oacs_pkg::RECIP_10_SHIFT +: PW];
        cmd_sel     = oacs_pkg::CMD_NONE;
        pct_sel     = '0;
        if (all_zero)
        begin
            cmd_sel = oacs_pkg::CMD_NONE;
        end
        else if (oacs_pkg::dominates(back_reg, left_reg, tolerance_reg)
                 && oacs_pkg::dominates(back_reg, right_reg, tolerance_reg)
                 && oacs_pkg::dominates(back_reg, fl_reg, tolerance_reg)
                 && oacs_pkg::dominates(back_reg, fr_reg, tolerance_reg))
        begin
            cmd_sel = oacs_pkg::CMD_ABOUT;
        end
        else if (oacs_pkg::dominates(left_reg, back_reg, tolerance_reg)
                 && oacs_pkg::dominates(left_reg, right_reg, tolerance_reg)
                 && oacs_pkg::dominates(left_reg, fl_reg, tolerance_reg)
                 && oacs_pkg::dominates(left_reg, fr_reg, tolerance_reg))
        begin
            cmd_sel = oacs_pkg::CMD_LEFT;
        end
        else if (oacs_pkg::dominates(right_reg, back_reg, tolerance_reg)
                 && oacs_pkg::dominates(right_reg, left_reg, tolerance_reg)
                 && oacs_pkg::dominates(right_reg, fl_reg, tolerance_reg)
                 && oacs_pkg::dominates(right_reg, fr_reg, tolerance_reg))
        begin
            cmd_sel = oacs_pkg::CMD_RIGHT;
        end
        else if (fl_reg > fr_reg)
        begin
            if (clear_ahead)
            begin
                cmd_sel = oacs_pkg::CMD_VEER_LEFT;
                pct_sel = dist_pct;
            end
            else
            begin
                cmd_sel = oacs_pkg::CMD_LEFT;
            end
        end
        else if (fl_reg < fr_reg)
        begin
            if (clear_ahead)
            begin
                cmd_sel = oacs_pkg::CMD_VEER_RIGHT;
                pct_sel = dist_pct;
            end
            else
            begin
                cmd_sel = oacs_pkg::CMD_RIGHT;
            end
        end
    end

    assign hist_push = (state_reg == oacs_pkg::ST_DECIDE);

    oacs_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (hist_push),
        .cmd   (cmd_sel),
        .pct   (pct_sel),
        .stat  (hist_stat)
    );

    // Forward time: 100 + (100 - p)^2 / 20 for an issued veer, else zero; split
    // as square, then quarter and divide by five through a reciprocal.
    always_comb
    begin
        if (hist_stat.issued == oacs_pkg::CMD_NONE)
        begin
            dev = oacs_pkg::PCT_CENTER;
        end
        else if (hist_stat.oldest_pct > oacs_pkg::PCT_CENTER)
        begin
            dev = hist_stat.oldest_pct - oacs_pkg::PCT_CENTER;
        end
        else
        begin
            dev = oacs_pkg::PCT_CENTER - hist_stat.oldest_pct;
        end
        scale_prod = {12'd0, sq_reg[SQ_W-1:2]} * {{QTR_W{1'b0}}, oacs_pkg::RECIP_5};
        if (issued_reg == oacs_pkg::CMD_VEER_LEFT || issued_reg == oacs_pkg::CMD_VEER_RIGHT)
        begin
            ftime = oacs_pkg::FTIME_BASE
                    + scale_prod[oacs_pkg::RECIP_5_SHIFT +: oacs_pkg::FTIME_W];
        end
        else
        begin
            ftime = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_push)
        begin
            cmd_reg <= cmd_sel;
        end
        if (state_reg == oacs_pkg::ST_SQUARE)
        begin
            issued_reg <= hist_stat.issued;
            oper_reg   <= (hist_stat.issued == oacs_pkg::CMD_NONE) ? '0 : hist_stat.oldest_pct;
            sq_reg     <= {{PW{1'b0}}, dev} * {{PW{1'b0}}, dev};
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oacs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        load_result = 1'b0;
        case (state_reg)
            oacs_pkg::ST_IDLE:
            begin
                if (scan_xfer)
                begin
                    state_next = oacs_pkg::ST_DIVIDE;
                end
            end
            oacs_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = oacs_pkg::ST_DECIDE;
                end
            end
            oacs_pkg::ST_DECIDE:
            begin
                state_next = oacs_pkg::ST_SQUARE;
            end
            oacs_pkg::ST_SQUARE:
            begin
                state_next = oacs_pkg::ST_SCALE;
            end
            oacs_pkg::ST_SCALE:
            begin
                // Hold until the output register is free.
                if (!result_valid_reg || result_ready)
                begin
                    load_result = 1'b1;
                    state_next  = oacs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oacs_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg.raw_command     <= cmd_reg;
            result_reg.issued_command  <= issued_reg;
            result_reg.move_percent    <= oper_reg;
            result_reg.forward_time_ms <= ftime;
            result_reg.range_cm        <= range_cm;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ src/oacs_div.sv @@
module oacs_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [oacs_pkg::RANGE_W-1:0]       dividend,
    input  logic [oacs_pkg::SAMPLE_BITS-1:0]   divisor,
    output logic                               done,
    output logic [oacs_pkg::RANGE_W-1:0]       quotient
);

    localparam int QW    = oacs_pkg::RANGE_W;
    localparam int DW    = oacs_pkg::SAMPLE_BITS;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [DW-1:0]    div_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, quo_reg[QW-1]};
        ge    = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done     = busy_reg && (cnt_reg == LAST);
    assign quotient = quo_reg;

endmodule

@@ src/oacs_hist.sv @@
module oacs_hist #(
    parameter int DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [oacs_pkg::CMD_W-1:0]       cmd,
    input  logic [oacs_pkg::PCT_W-1:0]       pct,
    output oacs_pkg::hist_stat_t             stat
);

    logic [oacs_pkg::CMD_W-1:0] cmd_reg [DEPTH];
    logic [oacs_pkg::PCT_W-1:0] pct_reg [DEPTH];
    logic                       agree;

    // Entry 0 is the newest; advance every entry by one on a push.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cmd_reg[i] <= oacs_pkg::CMD_NONE;
                pct_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            cmd_reg[0] <= cmd;
            pct_reg[0] <= pct;
            for (int i = 1; i < DEPTH; i++)
            begin
                cmd_reg[i] <= cmd_reg[i-1];
                pct_reg[i] <= pct_reg[i-1];
            end
        end
    end

    always_comb
    begin
        agree = 1'b1;
        for (int i = 1; i < DEPTH; i++)
        begin
            if (cmd_reg[i] != cmd_reg[0])
            begin
                agree = 1'b0;
            end
        end
        stat.issued     = agree ? cmd_reg[0] : oacs_pkg::CMD_NONE;
        stat.oldest_pct = pct_reg[DEPTH-1];
    end

endmodule
